// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/wsru_pkg.sv
package wsru_pkg;

    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OPCODE   = 2'd1;
    localparam logic [1:0] ERR_OVERSIZE = 2'd2;

    localparam logic [1:0] FK_DATA  = 2'd0;
    localparam logic [1:0] FK_CLOSE = 2'd1;
    localparam logic [1:0] FK_PING  = 2'd2;
    localparam logic [1:0] FK_PONG  = 2'd3;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_BYTES = 3'd0;
    localparam logic [2:0] MASK_LAST   = 3'd3;

    localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  cnt;
        logic [1:0]  fkind;
        logic        fin;
        logic        masked;
        logic [31:0] key;
        logic [1:0]  mphase;
        logic [1:0]  err;
        logic        len_hi;
    } wsru_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] fkind;
        logic       fin;
        logic       fend;
        logic [1:0] err;
    } wsru_result_t;

    function automatic logic known_opcode(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
               (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

    function automatic logic [1:0] kind_of(input logic [3:0] op);
        logic [1:0] k;
        k = FK_DATA;
        if (op == OP_CLOSE) k = FK_CLOSE;
        if (op == OP_PING) k = FK_PING;
        if (op == OP_PONG) k = FK_PONG;
        return k;
    endfunction

endpackage

// File: sv/wsru_parse.sv
module wsru_parse #(
    parameter int CNT_W = 32
) (
    input  wsru_pkg::wsru_state_t  st,
    input  logic [CNT_W-1:0]       rem,
    input  logic [7:0]             rx_byte,
    input  logic [31:0]            max_len,
    output wsru_pkg::wsru_state_t  st_next,
    output logic [CNT_W-1:0]       rem_next,
    output wsru_pkg::wsru_result_t res
);
    import wsru_pkg::*;

    logic             do_len;
    logic [CNT_W-1:0] len_val;
    logic             len_hi;
    logic             over;
    logic [2:0]       cnt_dec;
    logic [7:0]       key_byte;

    always_comb
    begin
        st_next  = st;
        rem_next = rem;
        res.kind = 1'b0;
        res.data = rx_byte;
        res.fend = 1'b0;
        do_len   = 1'b0;
        len_val  = '0;
        len_hi   = 1'b0;
        over     = 1'b0;
        cnt_dec  = st.cnt - 3'd1;
        key_byte = st.key[31:24];

        unique case (st.phase)
            PH_ERROR:
            begin
            end
            PH_HDR2:
            begin
                st_next.masked = rx_byte[7];
                st_next.cnt    = 3'd0;
                st_next.len_hi = 1'b0;
                rem_next       = '0;
                if (rx_byte[6:0] == LEN7_EXT16 || rx_byte[6:0] == LEN7_EXT64)
                begin
                    st_next.phase  = PH_EXTLEN;
                    st_next.mphase = (rx_byte[6:0] == LEN7_EXT16) ? 2'd0 : 2'd1;
                    st_next.cnt    = (rx_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES
                                                                   : EXT64_BYTES;
                end
                else
                begin
                    do_len  = 1'b1;
                    len_val = {{(CNT_W-7){1'b0}}, rx_byte[6:0]};
                end
            end
            PH_EXTLEN:
            begin
                len_val        = {rem[CNT_W-9:0], rx_byte};
                len_hi         = st.len_hi | (|rem[CNT_W-1 -: 8]);
                rem_next       = len_val;
                st_next.len_hi = len_hi;
                st_next.cnt    = cnt_dec;
                do_len         = (cnt_dec == 3'd0);
            end
            PH_MASK:
            begin
                st_next.key = {st.key[23:0], rx_byte};
                st_next.cnt = st.cnt + 3'd1;
                if (st.cnt == MASK_LAST)
                begin
                    st_next.cnt    = 3'd0;
                    st_next.mphase = 2'd0;
                    if (rem == '0)
                    begin
                        st_next.phase = PH_HDR1;
                        res.fend      = 1'b1;
                    end
                    else
                    begin
                        st_next.phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res.kind = 1'b1;
                unique case (st.mphase)
                    2'd0: key_byte = st.key[31:24];
                    2'd1: key_byte = st.key[23:16];
                    2'd2: key_byte = st.key[15:8];
                    default: key_byte = st.key[7:0];
                endcase
                if (st.masked)
                begin
                    res.data = rx_byte ^ key_byte;
                end
                st_next.mphase = st.mphase + 2'd1;
                if (rem <= {{(CNT_W-1){1'b0}}, 1'b1})
                begin
                    rem_next      = '0;
                    res.fend      = 1'b1;
                    st_next.phase = PH_HDR1;
                end
                else
                begin
                    rem_next = rem - {{(CNT_W-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                st_next.fkind = kind_of(rx_byte[3:0]);
                st_next.fin   = rx_byte[7];
                if (!known_opcode(rx_byte[3:0]))
                begin
                    st_next.err   = ERR_OPCODE;
                    st_next.phase = PH_ERROR;
                end
                else
                begin
                    st_next.phase = PH_HDR2;
                end
            end
        endcase

        if (do_len)
        begin
            over     = len_hi | ({{(33-CNT_W){1'b0}}, len_val} > {1'b0, max_len});
            rem_next = len_val;
            if (over)
            begin
                st_next.err   = ERR_OVERSIZE;
                st_next.phase = PH_ERROR;
            end
            else if (st_next.masked)
            begin
                st_next.phase = PH_MASK;
                st_next.cnt   = 3'd0;
                st_next.key   = '0;
            end
            else
            begin
                st_next.mphase = 2'd0;
                if (len_val == '0)
                begin
                    st_next.phase = PH_HDR1;
                    res.fend      = 1'b1;
                end
                else
                begin
                    st_next.phase = PH_PAYLOAD;
                end
            end
        end

        res.fkind = st_next.fkind;
        res.fin   = st_next.fin;
        res.err   = st_next.err;
    end

endmodule

// File: sv/websocket_frame_receive_unmask.sv
// Datapath: each byte is held in the input register, the parser computes its result and
// the result is registered in the result register; a stalled output holds both registers.
// Throughput: one byte per cycle while out_ready accepts results; the parser state updates in one
// pass between the input register and the result register, so bytes may follow back to back.
// Reset: rst_n is asynchronous and active low; the parser returns to the first header byte,
// the sticky error clears and max_len_reg returns to 65535.
module websocket_frame_receive_unmask #(
    parameter int LENGTH_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  frame_kind,
    output logic        is_final,
    output logic        frame_end,
    output logic [1:0]  error_code
);
    import wsru_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;

    logic [31:0]      max_len_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    wsru_state_t      st_reg;
    wsru_state_t      st_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    wsru_result_t     res_reg;
    wsru_result_t     res_next;
    logic             out_valid_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    wsru_parse #(
        .CNT_W (CNT_W)
    ) u_parse (
        .st       (st_reg),
        .rem      (rem_reg),
        .rx_byte  (in_byte_reg),
        .max_len  (max_len_reg),
        .st_next  (st_next),
        .rem_next (rem_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            rem_reg <= '0;
        end
        else if (advance)
        begin
            st_reg  <= st_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_kind  = res_reg.kind;
    assign data_byte  = res_reg.data;
    assign frame_kind = res_reg.fkind;
    assign is_final   = res_reg.fin;
    assign frame_end  = res_reg.fend;
    assign error_code = res_reg.err;

    `ASSERT_IMPLY(a_payload_no_error, clk, rst_n, out_valid_reg && res_reg.kind,
                  res_reg.err == ERR_NONE)
    `ASSERT_IMPLY(a_error_quiet, clk, rst_n, out_valid_reg && (res_reg.err != ERR_NONE),
                  !res_reg.fend && !res_reg.kind)
    `ASSERT_NEXT(a_error_sticky, clk, rst_n, st_reg.err != ERR_NONE,
                 $stable(st_reg.err) && (st_reg.phase == PH_ERROR))
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid_reg, in_ready)

endmodule

// File: bench/wsru_frame_checker.sv
`timescale 1ns / 1ps

module wsru_frame_checker
    import wsru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        byte_kind,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  frame_kind,
    input  logic        is_final,
    input  logic        frame_end,
    input  logic [1:0]  error_code,
    output int          mismatch_count,
    output int          outstanding
);

    localparam logic [3:0] EXT16_LEN_BYTES = 4'd2;
    localparam logic [3:0] EXT64_LEN_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES       = 4'd4;
    localparam int         REPORT_LIMIT    = 10;

    logic [2:0]  rx_phase;
    logic [3:0]  byte_cnt;
    logic [3:0]  opcode;
    logic        fin_bit;
    logic        masked_bit;
    logic [31:0] mask_key;
    logic [63:0] remaining;
    logic [1:0]  key_index;
    logic [1:0]  err_state;
    logic [31:0] len_limit;

    wsru_result_t expected_bytes[$];

    function automatic logic opcode_valid(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [1:0] class_of(input logic [3:0] op);
        case (op)
            OP_CLOSE: return FK_CLOSE;
            OP_PING:  return FK_PING;
            OP_PONG:  return FK_PONG;
            default:  return FK_DATA;
        endcase
    endfunction

    function automatic logic start_payload();
        key_index = 2'd0;
        if (remaining == 64'd0)
        begin
            rx_phase = PH_HDR1;
            return 1'b1;
        end
        rx_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic logic finish_length();
        if (remaining > {32'd0, len_limit})
        begin
            err_state = ERR_OVERSIZE;
            rx_phase = PH_ERROR;
            return 1'b0;
        end
        if (masked_bit)
        begin
            rx_phase = PH_MASK;
            byte_cnt = 4'd0;
            mask_key = 32'd0;
            return 1'b0;
        end
        return start_payload();
    endfunction

    function automatic wsru_result_t unmask_rx_byte(input logic [7:0] b);
        wsru_result_t r;
        r.kind = 1'b0;
        r.data = b;
        r.fend = 1'b0;
        case (rx_phase)
            PH_ERROR: ;
            PH_HDR2:
            begin
                masked_bit = b[7];
                remaining = 64'd0;
                byte_cnt = 4'd0;
                if (b[6:0] == LEN7_EXT16)
                begin
                    rx_phase = PH_EXTLEN;
                    byte_cnt = EXT16_LEN_BYTES;
                end
                else if (b[6:0] == LEN7_EXT64)
                begin
                    rx_phase = PH_EXTLEN;
                    byte_cnt = EXT64_LEN_BYTES;
                end
                else
                begin
                    remaining = 64'(b[6:0]);
                    r.fend = finish_length();
                end
            end
            PH_EXTLEN:
            begin
                remaining = {remaining[55:0], b};
                byte_cnt = byte_cnt - 4'd1;
                if (byte_cnt == 4'd0)
                    r.fend = finish_length();
            end
            PH_MASK:
            begin
                mask_key = {mask_key[23:0], b};
                byte_cnt = byte_cnt + 4'd1;
                if (byte_cnt >= KEY_BYTES)
                begin
                    byte_cnt = 4'd0;
                    r.fend = start_payload();
                end
            end
            PH_PAYLOAD:
            begin
                r.kind = 1'b1;
                if (masked_bit)
                    r.data = b ^ mask_key[8 * (3 - int'(key_index)) +: 8];
                key_index = key_index + 2'd1;
                if (remaining <= 64'd1)
                begin
                    remaining = 64'd0;
                    r.fend = 1'b1;
                    rx_phase = PH_HDR1;
                end
                else
                    remaining = remaining - 64'd1;
            end
            default:
            begin
                opcode = b[3:0];
                fin_bit = b[7];
                if (opcode_valid(b[3:0]))
                    rx_phase = PH_HDR2;
                else
                begin
                    err_state = ERR_OPCODE;
                    rx_phase = PH_ERROR;
                end
            end
        endcase
        r.fkind = class_of(opcode);
        r.fin = fin_bit;
        r.err = err_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wsru_result_t seen;
        wsru_result_t want;
        if (!rst_n)
        begin
            rx_phase = PH_HDR1;
            byte_cnt = 4'd0;
            opcode = OP_CONT;
            fin_bit = 1'b0;
            masked_bit = 1'b0;
            mask_key = 32'd0;
            remaining = 64'd0;
            key_index = 2'd0;
            err_state = ERR_NONE;
            len_limit = MAX_LEN_RESET;
            expected_bytes.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                len_limit = cfg_wdata;
            if (out_valid && out_ready)
            begin
                seen.kind = byte_kind;
                seen.data = data_byte;
                seen.fkind = frame_kind;
                seen.fin = is_final;
                seen.fend = frame_end;
                seen.err = error_code;
                if (expected_bytes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result transfer with none expected: kind=%0d data=%02h",
                                 $realtime, seen.kind, seen.data);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (seen != want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected kind=%0d data=%02h fkind=%0d ",
                                      "fin=%0d end=%0d err=%0d, got kind=%0d data=%02h ",
                                      "fkind=%0d fin=%0d end=%0d err=%0d"},
                                     $realtime, want.kind, want.data, want.fkind, want.fin,
                                     want.fend, want.err, seen.kind, seen.data, seen.fkind,
                                     seen.fin, seen.fend, seen.err);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_bytes.push_back(unmask_rx_byte(rx_byte));
            outstanding = expected_bytes.size();
        end
    end

endmodule

// File: bench/tb_websocket_frame_receive_unmask.sv
`timescale 1ns / 1ps

module tb_websocket_frame_receive_unmask;
    import wsru_pkg::*;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

    localparam int PHASE_BYTES = 530;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        byte_kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_kind;
    logic        is_final;
    logic        frame_end;
    logic [1:0]  error_code;

    int          mismatch_count;
    int          outstanding;
    int          send_idle;
    int          recv_idle;
    int          bytes_sent;
    logic [31:0] cur_limit;

    websocket_frame_receive_unmask u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_kind  (byte_kind),
        .data_byte  (data_byte),
        .frame_kind (frame_kind),
        .is_final   (is_final),
        .frame_end  (frame_end),
        .error_code (error_code)
    );

    wsru_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_kind      (byte_kind),
        .data_byte      (data_byte),
        .frame_kind     (frame_kind),
        .is_final       (is_final),
        .frame_end      (frame_end),
        .error_code     (error_code),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic write_limit(input logic [31:0] value);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_limit = value;
    endtask

    task automatic send_frame(input logic [3:0] op, input logic fin, input logic masked,
                              input len_form_e form, input logic [63:0] len);
        logic [31:0] key;
        key = $urandom();
        push_byte({fin, 3'($urandom_range(0, 7)), op});
        case (form)
            LEN_SHORT:
                push_byte({masked, len[6:0]});
            LEN_EXT16:
            begin
                push_byte({masked, LEN7_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default:
            begin
                push_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                push_byte(key[8 * i +: 8]);
        repeat (len)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_frame();
        logic [3:0]  op;
        len_form_e   form;
        logic [63:0] len;
        int          pick;
        case ($urandom_range(0, 5))
            0: op = OP_CONT;
            1: op = OP_TEXT;
            2: op = OP_BINARY;
            3: op = OP_CLOSE;
            4: op = OP_PING;
            default: op = OP_PONG;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            form = LEN_SHORT;
            len = 64'($urandom_range(0, 16));
        end
        else if (pick < 75)
        begin
            form = LEN_SHORT;
            len = 64'($urandom_range(17, 125));
        end
        else if (pick < 90)
        begin
            form = LEN_EXT16;
            len = 64'($urandom_range(0, 400));
        end
        else
        begin
            form = LEN_EXT64;
            len = 64'($urandom_range(0, 200));
        end
        if (len > {32'd0, cur_limit})
            len = {32'd0, cur_limit};
        send_frame(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), form, len);
    endtask

    task automatic random_phase(input int sender_gap, input int receiver_gap,
                                input logic [31:0] limit);
        send_idle = sender_gap;
        recv_idle = receiver_gap;
        write_limit(limit);
        bytes_sent = 0;
        while (bytes_sent < PHASE_BYTES)
            random_frame();
    endtask

    initial
    begin
        int          pick;
        logic [3:0]  bad_op;
        logic [63:0] over_len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 32'd0;
        in_valid = 1'b0;
        rx_byte = 8'd0;
        send_idle = 17;
        recv_idle = 65;
        bytes_sent = 0;
        cur_limit = MAX_LEN_RESET;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(OP_TEXT, 1'b1, 1'b0, LEN_SHORT, 64'd0);
        send_frame(OP_BINARY, 1'b0, 1'b1, LEN_SHORT, 64'd2);
        send_frame(OP_CLOSE, 1'b1, 1'b1, LEN_SHORT, 64'd0);
        send_frame(OP_PING, 1'b1, 1'b0, LEN_EXT16, 64'd1);
        send_frame(OP_PONG, 1'b1, 1'b0, LEN_EXT64, 64'd0);
        write_limit(32'd0);
        send_frame(OP_CONT, 1'b0, 1'b0, LEN_EXT16, 64'd0);

        random_phase(17, 65, 32'd300);
        random_phase(65, 17, MAX_LEN_RESET);
        random_phase(0, 0, 32'hFFFF_FFFF);

        // The error is sticky until reset, so exactly one kind can be reached per run.
        if ($urandom_range(0, 1) == 1)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                bad_op = OP_BINARY + 4'd1 + 4'(pick);
            else
                bad_op = OP_PONG + 4'd1 + 4'(pick - 5);
            push_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), bad_op});
        end
        else
        begin
            push_byte({1'b1, 3'b000, OP_BINARY});
            push_byte({1'b0, LEN7_EXT64});
            over_len = {32'd1, 32'($urandom())};
            for (int i = 7; i >= 0; i--)
                push_byte(over_len[8 * i +: 8]);
        end
        repeat (20)
            push_byte(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/wsru_pkg.sv
sv/wsru_parse.sv
sv/websocket_frame_receive_unmask.sv
bench/wsru_frame_checker.sv
bench/tb_websocket_frame_receive_unmask.sv
